>>> rtl/u2rd_pkg.sv
// Shared types and constants for the unsigned-to-radix-digits converter.
// Used by u2rd_divider and unsigned_to_radix_digits; no dependencies.
package u2rd_pkg;

    // Default parameter values
    localparam int DEF_MAX_RADIX   = 16;
    localparam int DEF_VALUE_WIDTH = 64;

    // Quotient bits resolved per divider cycle
    localparam int STEP_BITS = 4;

    // Fixed field widths of the ports
    localparam int VALUE_FIELD_W = 64;
    localparam int CHAR_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int RADIX_REG_W   = 5;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

    // Reset values of the registers
    localparam logic [RADIX_REG_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [CFG_DATA_W-1:0]  CHARS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0]  CHARS_HIGH_RESET = 64'h6665646362613938;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SHOW
    } u2rd_state_t;

    // Sequencer to divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Alphabet lookup: digits 0..7 in the low word, 8..15 in the high word
    function automatic logic [CHAR_W-1:0] char_of_digit(
        input logic [3:0]            sel,
        input logic [CFG_DATA_W-1:0] chars_low,
        input logic [CFG_DATA_W-1:0] chars_high
    );
        logic [CFG_DATA_W-1:0] word;
        word = sel[3] ? chars_high : chars_low;
        return word[sel[2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

>>> rtl/u2rd_divider.sv
// Iterative divider: divides a value by a small radix, STEP_BITS quotient bits per cycle.
// Depends on u2rd_pkg (control/status structs, STEP_BITS).
module u2rd_divider #(
    parameter int VALUE_WIDTH = u2rd_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_RADIX   = u2rd_pkg::DEF_MAX_RADIX
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  u2rd_pkg::div_ctrl_t                    ctrl,
    input  logic [((VALUE_WIDTH + u2rd_pkg::STEP_BITS - 1) / u2rd_pkg::STEP_BITS)
                  * u2rd_pkg::STEP_BITS - 1:0]     dividend,
    input  logic [$clog2(MAX_RADIX + 1) - 1:0]     radix,
    output u2rd_pkg::div_stat_t                    status,
    output logic [((VALUE_WIDTH + u2rd_pkg::STEP_BITS - 1) / u2rd_pkg::STEP_BITS)
                  * u2rd_pkg::STEP_BITS - 1:0]     quotient,
    output logic [$clog2(MAX_RADIX) - 1:0]         remainder
);
    import u2rd_pkg::*;

    localparam int PAD_W   = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int NSTEPS  = PAD_W / STEP_BITS;
    localparam int STEP_W  = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
    localparam int DIGIT_W = $clog2(MAX_RADIX);
    localparam int TW      = DIGIT_W + 1;

    logic [PAD_W-1:0]   shift_reg, shift_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [PAD_W-1:0]   sh_v;
    logic [DIGIT_W-1:0] rem_v;
    logic [TW-1:0]      t_v;
    logic [TW-1:0]      rad_ext;
    logic               qbit;

    assign rad_ext = TW'(radix);

    // STEP_BITS restoring steps; quotient bits shift in at the bottom
    always_comb
    begin
        sh_v  = shift_reg;
        rem_v = rem_reg;
        t_v   = '0;
        qbit  = 1'b0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t_v = {rem_v, sh_v[PAD_W-1]};
            if (t_v >= rad_ext)
            begin
                rem_v = DIGIT_W'(t_v - rad_ext);
                qbit  = 1'b1;
            end
            else
            begin
                rem_v = DIGIT_W'(t_v);
                qbit  = 1'b0;
            end
            sh_v = {sh_v[PAD_W-2:0], qbit};
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            step_next  = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = sh_v;
            rem_next   = rem_v;
            step_next  = step_reg + 1'b1;
            if (step_reg == STEP_W'(NSTEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = shift_reg;
    assign remainder   = rem_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (TW'(rem_reg) < rad_ext))
        else $error("remainder not below radix");

endmodule

>>> rtl/unsigned_to_radix_digits.sv
// Top level: converts an unsigned value to radix digits, most significant first.
// Depends on u2rd_pkg and u2rd_divider; holds the digit memory and the sequencer.
//
//  channel | direction | handshake         | payload
//  s_*     | in        | s_tvalid/s_tready | s_tdata[63:0] = value
//  m_*     | out       | m_tvalid/m_tready | m_tdata[7:0] = character, m_tlast = last_digit
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index (0 radix, 1 chars low, 2 chars high), cfg_data
//
// One value at a time. Each digit costs one division pass of the shared divider.
// Digits go into a memory and are then read back in reverse; each character takes
// a read state and a show state, plus any output stall time.
// Reset clears the sequencer and loads the register defaults; no clearing pass.
// cfg_ready is always high.
module unsigned_to_radix_digits #(
    parameter int MAX_RADIX   = u2rd_pkg::DEF_MAX_RADIX,
    parameter int VALUE_WIDTH = u2rd_pkg::DEF_VALUE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u2rd_pkg::VALUE_FIELD_W-1:0] s_tdata,   // [63:0] value
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u2rd_pkg::CHAR_W-1:0]        m_tdata,   // [7:0] character
    output logic                               m_tlast,   // last_digit
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [u2rd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [u2rd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import u2rd_pkg::*;

    localparam int PAD_W   = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int DIGIT_W = $clog2(MAX_RADIX);
    localparam int RADIX_W = $clog2(MAX_RADIX + 1);
    localparam int ADDR_W  = $clog2(VALUE_WIDTH);
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);

    u2rd_state_t state_reg, state_next;

    logic [RADIX_REG_W-1:0] radix_reg;
    logic [CFG_DATA_W-1:0]  chars_low_reg;
    logic [CFG_DATA_W-1:0]  chars_high_reg;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [DIGIT_W-1:0] digit_rd_reg;
    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

    logic [RADIX_W-1:0] eff_radix;
    logic               in_acc, out_acc, mem_we, q_zero;

    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic [PAD_W-1:0]   div_dividend, div_quot;
    logic [DIGIT_W-1:0] div_rem;

    // Clamp the radix register to 2..MAX_RADIX
    always_comb
    begin
        if (radix_reg < RADIX_REG_W'(2))
            eff_radix = RADIX_W'(2);
        else if (radix_reg > RADIX_REG_W'(MAX_RADIX))
            eff_radix = RADIX_W'(MAX_RADIX);
        else
            eff_radix = RADIX_W'(radix_reg);
    end

    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign q_zero    = (div_quot == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RESET;
            chars_low_reg  <= CHARS_LOW_RESET;
            chars_high_reg <= CHARS_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RADIX:      radix_reg      <= cfg_data[RADIX_REG_W-1:0];
                CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_stat.done && q_zero)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_SHOW;
            ST_SHOW:
                if (out_acc)
                    state_next = m_tlast ? ST_IDLE : ST_READ;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        div_ctrl      = '0;
        div_dividend  = div_quot;
        mem_we        = 1'b0;
        cnt_next      = cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                div_dividend = PAD_W'(s_tdata[VALUE_WIDTH-1:0]);
                div_ctrl.start = in_acc;
                cnt_next     = '0;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (q_zero)
                        rd_ptr_next = cnt_reg[ADDR_W-1:0];
                    else
                        div_ctrl.start = 1'b1;
                end
            end
            ST_READ:
            begin
            end
            ST_SHOW:
            begin
                m_tvalid = 1'b1;
                if (out_acc && !m_tlast)
                    rd_ptr_next = rd_ptr_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tlast = (rd_ptr_reg == '0);
    assign m_tdata = char_of_digit(4'(digit_rd_reg), chars_low_reg, chars_high_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Digit memory: written in division order, read back in reverse
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[cnt_reg[ADDR_W-1:0]] <= div_rem;
        digit_rd_reg <= digit_mem[rd_ptr_reg];
    end

    u2rd_divider #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_RADIX   (MAX_RADIX)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .radix     (eff_radix),
        .status    (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("new item taken while one is in flight");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_tlast) |=> s_tready)
        else $error("not idle after last character");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result outside division phase");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (cnt_reg < CNT_W'(VALUE_WIDTH)))
        else $error("digit count overflow");

endmodule
